// File: rtl/rms_difference_unit_macros.svh
// ----------------------------------------------------------------------------
// rms difference unit assertion macros
// shared concurrent assertion shorthands, clocked on clk_i, gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef RMS_DIFFERENCE_UNIT_MACROS_SVH
`define RMS_DIFFERENCE_UNIT_MACROS_SVH

// same-cycle implication
`define RDU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rdu same-cycle check failed");

// next-cycle implication
`define RDU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rdu next-cycle check failed");

`endif

// File: rtl/rdu_pkg.sv
// ----------------------------------------------------------------------------
// rdu_pkg
// types and fixed constants of the rms difference unit
// ----------------------------------------------------------------------------
package rdu_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SumW    = 48;
  localparam int unsigned CountW  = 17;
  localparam int unsigned RmsW    = 24;
  localparam int unsigned QuotW   = 48;
  localparam int unsigned RemW    = 26;
  localparam int unsigned AluW    = 28;

  // restoring divide runs one quotient bit per step, root two radicand bits
  localparam int unsigned DivSteps  = QuotW;
  localparam int unsigned SqrtSteps = RmsW;
  localparam int unsigned StepW     = $clog2(DivSteps);

  // accumulated vector handed to the divide/root engine
  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] count;
    logic              ovf;
  } job_t;

  // finished result from the engine
  typedef struct packed {
    logic [RmsW-1:0]   rms;
    logic [CountW-1:0] count;
    logic              ovf;
  } result_t;

endpackage

// File: rtl/rdu_if.sv
// ----------------------------------------------------------------------------
// rdu channel interfaces
// valid/ready channels for sample pairs and rms results
// ----------------------------------------------------------------------------
interface rdu_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_a;
  logic signed [15:0] sample_b;
  logic               last;

  modport source (output valid, sample_a, sample_b, last, input ready);
  modport sink   (input valid, sample_a, sample_b, last, output ready);
endinterface

interface rdu_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] rms_q8;
  logic [16:0] pair_count;
  logic        too_long;

  modport source (output valid, rms_q8, pair_count, too_long, input ready);
  modport sink   (input valid, rms_q8, pair_count, too_long, output ready);
endinterface

// File: rtl/rdu_cmpsub.sv
// ----------------------------------------------------------------------------
// rdu_cmpsub
// shared compare-and-subtract unit used by the divide and root steps
// ----------------------------------------------------------------------------
module rdu_cmpsub (
  input  logic [rdu_pkg::AluW-1:0] a_i,
  input  logic [rdu_pkg::AluW-1:0] b_i,
  output logic [rdu_pkg::AluW-1:0] diff_o,
  output logic                     ge_o
);

  logic [rdu_pkg::AluW:0] full;

  // one wide subtract, borrow gives the compare
  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[rdu_pkg::AluW-1:0];
  assign ge_o   = ~full[rdu_pkg::AluW];

endmodule

// File: rtl/rdu_accum.sv
// ----------------------------------------------------------------------------
// rdu_accum
// squared-difference accumulator with pair count and overflow flag
// ----------------------------------------------------------------------------
module rdu_accum #(
  parameter int unsigned MaxItems = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic signed [15:0]   sample_a_i,
  input  logic signed [15:0]   sample_b_i,
  input  logic                 last_i,
  output rdu_pkg::job_t        job_o
);

  logic [rdu_pkg::SumW-1:0]   sum_q, sum_d;
  logic [rdu_pkg::CountW-1:0] count_q, count_d;
  logic                       ovf_q, ovf_d;
  logic [16:0]                diff;
  logic [16:0]                mag_full;
  logic [15:0]                mag;
  logic [31:0]                sq;
  logic                       full;

  // exact 17-bit difference and its magnitude
  assign diff     = {sample_a_i[15], sample_a_i} - {sample_b_i[15], sample_b_i};
  assign mag_full = diff[16] ? (~diff + 17'd1) : diff;
  assign mag      = mag_full[15:0];
  assign sq       = 32'(mag) * 32'(mag);

  // pairs past the limit are dropped and flagged
  assign full = (count_q == rdu_pkg::CountW'(MaxItems));

  assign job_o.sum   = full ? sum_q : sum_q + rdu_pkg::SumW'(sq);
  assign job_o.count = full ? count_q : count_q + 1'b1;
  assign job_o.ovf   = ovf_q | full;

  // clear after the last pair, otherwise keep the running totals
  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (take_i) begin
      if (last_i) begin
        sum_d   = '0;
        count_d = '0;
        ovf_d   = 1'b0;
      end else begin
        sum_d   = job_o.sum;
        count_d = job_o.count;
        ovf_d   = job_o.ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// File: rtl/rdu_engine.sv
// ----------------------------------------------------------------------------
// rdu_engine
// sequencer for the restoring divide and the integer square root,
// both stepping through one shared compare-and-subtract unit
// ----------------------------------------------------------------------------
module rdu_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rdu_pkg::job_t      job_i,
  input  logic               load_i,
  output logic               idle_o,
  output logic               done_o,
  output rdu_pkg::result_t   res_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StSqrt = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  localparam int unsigned AluW = rdu_pkg::AluW;
  localparam int unsigned RemW = rdu_pkg::RemW;
  localparam int unsigned CntW = rdu_pkg::CountW;
  localparam int unsigned QW   = rdu_pkg::QuotW;
  localparam int unsigned RtW  = rdu_pkg::RmsW;
  localparam int unsigned SW   = rdu_pkg::StepW;

  logic [1:0]      state_q, state_d;
  logic [SW-1:0]   step_q, step_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [QW-1:0]   dvd_q, dvd_d;
  logic [RtW-1:0]  root_q, root_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;

  logic [AluW-1:0] alu_a, alu_b, alu_diff;
  logic            alu_ge;

  // operand selection for the shared unit
  always_comb begin
    if (state_q == StSqrt) begin
      alu_a = {rem_q, dvd_q[QW-1 -: 2]};
      alu_b = {2'b00, root_q, 2'b01};
    end else begin
      alu_a = AluW'({rem_q[CntW-1:0], dvd_q[QW-1]});
      alu_b = AluW'(count_q);
    end
  end

  rdu_cmpsub u_cmpsub (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    root_d  = root_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          // high sum bits are already below the count, so 48 steps suffice
          rem_d   = RemW'(job_i.sum[rdu_pkg::SumW-1:32]);
          dvd_d   = {job_i.sum[31:0], 16'h0000};
          count_d = job_i.count;
          ovf_d   = job_i.ovf;
          step_d  = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        rem_d  = alu_ge ? RemW'(alu_diff[CntW-1:0]) : RemW'(alu_a[CntW-1:0]);
        dvd_d  = {dvd_q[QW-2:0], alu_ge};
        step_d = step_q + 1'b1;
        if (step_q == SW'(rdu_pkg::DivSteps - 1)) begin
          step_d  = '0;
          state_d = StSqrt;
        end
      end
      StSqrt: begin
        if (step_q == '0) begin
          // fresh root: remainder of the divide is no longer needed
          rem_d = '0;
        end
        rem_d  = alu_ge ? alu_diff[RemW-1:0] : alu_a[RemW-1:0];
        root_d = {root_q[RtW-2:0], alu_ge};
        dvd_d  = {dvd_q[QW-3:0], 2'b00};
        step_d = step_q + 1'b1;
        if (step_q == SW'(rdu_pkg::SqrtSteps - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    // root and remainder start from zero when the divide finishes
    if (state_q == StDiv && state_d == StSqrt) begin
      rem_d  = '0;
      root_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    root_q  <= root_d;
    count_q <= count_d;
    ovf_q   <= ovf_d;
  end

  assign idle_o    = (state_q == StIdle);
  assign done_o    = (state_q == StDone);
  assign res_o.rms   = (count_q == '0) ? '0 : root_q;
  assign res_o.count = count_q;
  assign res_o.ovf   = ovf_q;

endmodule

// File: rtl/rms_difference_unit.sv
// ----------------------------------------------------------------------------
// rms_difference_unit
// root mean square difference of two sample vectors, 8 extra fraction bits
// ----------------------------------------------------------------------------
// pair_i takes one pair of signed 16-bit samples per transaction; last marks
// the final pair of a vector. res_o gives one transaction per vector:
// rms_q8 = floor(sqrt(floor(sum * 2^16 / count))), the pair count and a flag
// for pairs dropped past MAX_ITEMS.
// pairs not marked last are taken one per cycle while the engine is idle (one
// 16x16 square and a 48-bit add). after a last pair, ready stays low through
// a 48-step restoring divide, a 24-step square root and the hand-off to the
// output register, all through one shared 28-bit compare-and-subtract unit.
// the result sits in an output register: a stalled receiver does not stop
// accumulation of the next vector; only a second finished result waits
// (ready stays low) until the first is taken.
// reset clears the running sum, count, flag, sequencer and output valid.
// ----------------------------------------------------------------------------
module rms_difference_unit #(
  parameter int unsigned MAX_ITEMS = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rdu_in_if.sink        pair_i,
  rdu_out_if.source     res_o
);

  `include "rms_difference_unit_macros.svh"

  logic                    take;
  logic                    eng_idle, eng_done, eng_load;
  rdu_pkg::job_t           job;
  rdu_pkg::result_t        eng_res;
  logic                    out_valid_q, out_valid_d;
  rdu_pkg::result_t        out_q;

  // input transaction
  assign pair_i.ready = eng_idle;
  assign take         = pair_i.valid & pair_i.ready;

  rdu_accum #(
    .MaxItems (MAX_ITEMS)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .sample_a_i (pair_i.sample_a),
    .sample_b_i (pair_i.sample_b),
    .last_i     (pair_i.last),
    .job_o      (job)
  );

  rdu_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (take & pair_i.last),
    .job_i   (job),
    .load_i  (eng_load),
    .idle_o  (eng_idle),
    .done_o  (eng_done),
    .res_o   (eng_res)
  );

  // output register, refilled when empty or being drained
  assign eng_load = eng_done & (~out_valid_q | res_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (eng_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_load) begin
      out_q <= eng_res;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.rms_q8     = out_q.rms;
  assign res_o.pair_count = out_q.count;
  assign res_o.too_long   = out_q.ovf;

  // checks
  `RDU_ASSERT_NXT(a_busy_after_last, take && pair_i.last, !pair_i.ready)
  `RDU_ASSERT_IMP(a_count_nonzero, res_o.valid, res_o.pair_count != 17'd0)
  `RDU_ASSERT_IMP(a_flag_at_limit, res_o.valid && res_o.too_long,
                  res_o.pair_count == 17'(MAX_ITEMS))
  `RDU_ASSERT_IMP(a_rms_bound, res_o.valid, res_o.rms_q8 <= 24'd16776960)

endmodule
